[hw/rtl/xmcrc_pkg.sv]
// Shared types and constants for the XMODEM-CRC sender.
// Used by xmcrc_crc and xmodem_crc_sender; depends on nothing.
`timescale 1ns / 1ps

package xmcrc_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int PKT_BYTES     = PAYLOAD_BYTES + 5;
    localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0] FILL_FULL  = 8'(PAYLOAD_BYTES);
    localparam logic [7:0] POS_HDR    = 8'd3;
    localparam logic [7:0] POS_CRC_HI = 8'(PKT_BYTES - 2);
    localparam logic [7:0] POS_LAST   = 8'(PKT_BYTES - 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_PAD = 8'h1A;

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    typedef enum logic [2:0] {
        ST_BUSY   = 3'd0,
        ST_ACKED  = 3'd1,
        ST_DONE   = 3'd2,
        ST_CANCEL = 3'd3,
        ST_REJECT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_COLLECT  = 3'd0,
        PH_WAIT_PKT = 3'd1,
        PH_WAIT_EOT = 3'd2,
        PH_DONE     = 3'd3,
        PH_CANCEL   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_CRC   = 3'd1,
        S_PAD   = 3'd2,
        S_FETCH = 3'd3,
        S_BYTE  = 3'd4,
        S_EMIT  = 3'd5
    } state_t;

endpackage

[hw/rtl/xmcrc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module xmcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/xmcrc_crc.sv]
// Bit-serial CRC-16/XMODEM: one data bit per cycle.
// Depends on xmcrc_pkg.
`timescale 1ns / 1ps

module xmcrc_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        clear,
    input  logic [7:0]  din,
    output logic [15:0] crc,
    output logic        busy
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sh_reg, sh_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        fb;

    assign fb = crc_reg[15] ^ sh_reg[7];

    always_comb
    begin
        crc_next = crc_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (clear)
        begin
            crc_next = '0;
        end
        else if (start)
        begin
            sh_next  = din;
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = {crc_reg[14:0], 1'b0} ^ (fb ? xmcrc_pkg::CRC_POLY : 16'h0000);
            sh_next  = {sh_reg[6:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign crc  = crc_reg;
    assign busy = (cnt_reg != 4'd0);

endmodule

[hw/rtl/xmodem_crc_sender.sv]
// Top level of the XMODEM-CRC sender: sequencer, payload RAM, packet assembly.
// Depends on xmcrc_pkg, xmcrc_ram and xmcrc_crc.
//
// Input channel s_axis: tuser carries op (data byte, end of data, reply byte),
// tdata carries the byte. Output channel m_axis: tdata carries tx_word, tx_count
// and status; tlast marks the final result of an input item.
// A data byte is shifted through the bit-serial CRC unit; then S_EMIT loads its
// result into the output register (a full payload first builds the packet), and
// the next item is taken once the sequencer is back in S_IDLE.
// A packet of 133 bytes is built byte by byte, each in S_FETCH then S_BYTE
// (payload RAM read is registered), with each word of 8 bytes sent from S_EMIT.
// End of data with a partial payload pads each missing byte through the CRC
// unit before the packet starts.
// Input is taken only while the sequencer is idle; a finished result may still
// sit in the output register then. If the receiver stalls, the sequencer holds
// the next word until the output register frees up.
// Reset clears the sequencer, CRC, fill count and output valid; the block
// number returns to one and the block starts collecting. No clearing pass.
`timescale 1ns / 1ps

module xmodem_crc_sender #(
    parameter int BYTES_PER_WORD = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] tx_word, [67:64] tx_count,
                                        // [70:68] status, [71] zero
    output logic        m_axis_tlast    // last_of_run
);

    localparam logic [3:0] WORD_FULL = 4'(BYTES_PER_WORD);

    xmcrc_pkg::state_t  state_reg, state_next;
    xmcrc_pkg::phase_t  phase_reg, phase_next;
    xmcrc_pkg::status_t st_reg, st_next;

    logic [7:0]  fill_reg, fill_next;
    logic [7:0]  blk_reg, blk_next;
    logic        final_reg, final_next;
    logic [7:0]  pos_reg, pos_next;
    logic [63:0] wd_reg, wd_next;
    logic [3:0]  wcnt_reg, wcnt_next;
    logic        lst_reg, lst_next;

    logic        ovalid_reg, ovalid_next;
    logic [71:0] odata_reg, odata_next;
    logic        olast_reg, olast_next;

    logic                         ram_we;
    logic [xmcrc_pkg::ADDR_W-1:0] ram_waddr;
    logic [7:0]                   ram_wdata;
    logic [xmcrc_pkg::ADDR_W-1:0] ram_raddr;
    logic [7:0]                   ram_rdata;
    logic [7:0]                   ram_idx;

    logic        crc_start, crc_clear, crc_busy;
    logic [7:0]  crc_din;
    logic [15:0] crc_val;

    logic        in_acc, out_free, is_ack, is_can, fill_full, word_done;
    logic [1:0]  op;
    logic [7:0]  v;
    logic [7:0]  pkt_byte;
    logic [5:0]  lane_base;

    assign op        = s_axis_tuser;
    assign v         = s_axis_tdata;
    assign in_acc    = s_axis_tvalid && (state_reg == xmcrc_pkg::S_IDLE);
    assign out_free  = !ovalid_reg || m_axis_tready;
    assign is_ack    = (v == xmcrc_pkg::CH_ACK);
    assign is_can    = (v == xmcrc_pkg::CH_CAN);
    assign fill_full = (fill_reg == xmcrc_pkg::FILL_FULL);
    assign word_done = ((wcnt_reg + 4'd1) == WORD_FULL) || (pos_reg == xmcrc_pkg::POS_LAST);
    assign ram_idx   = pos_reg - xmcrc_pkg::POS_HDR;
    assign ram_raddr = ram_idx[xmcrc_pkg::ADDR_W-1:0];
    assign lane_base = {wcnt_reg[2:0], 3'b000};

    always_comb
    begin
        if (pos_reg == 8'd0)
        begin
            pkt_byte = xmcrc_pkg::CH_SOH;
        end
        else if (pos_reg == 8'd1)
        begin
            pkt_byte = blk_reg;
        end
        else if (pos_reg == 8'd2)
        begin
            pkt_byte = ~blk_reg;
        end
        else if (pos_reg == xmcrc_pkg::POS_CRC_HI)
        begin
            pkt_byte = crc_val[15:8];
        end
        else if (pos_reg == xmcrc_pkg::POS_LAST)
        begin
            pkt_byte = crc_val[7:0];
        end
        else
        begin
            pkt_byte = ram_rdata;
        end
    end

    xmcrc_ram #(
        .WIDTH (8),
        .DEPTH (xmcrc_pkg::PAYLOAD_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    xmcrc_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (crc_start),
        .clear (crc_clear),
        .din   (crc_din),
        .crc   (crc_val),
        .busy  (crc_busy)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xmcrc_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = xmcrc_pkg::S_EMIT;
                    if (phase_reg == xmcrc_pkg::PH_COLLECT)
                    begin
                        if (op == xmcrc_pkg::OP_DATA)
                        begin
                            state_next = xmcrc_pkg::S_CRC;
                        end
                        else if (op == xmcrc_pkg::OP_END && fill_reg != 8'd0)
                        begin
                            state_next = xmcrc_pkg::S_PAD;
                        end
                    end
                    else if (phase_reg == xmcrc_pkg::PH_WAIT_PKT &&
                             op == xmcrc_pkg::OP_REPLY && !is_ack && !is_can)
                    begin
                        state_next = xmcrc_pkg::S_FETCH;
                    end
                end
            end
            xmcrc_pkg::S_CRC:
            begin
                if (!crc_busy)
                begin
                    state_next = fill_full ? xmcrc_pkg::S_FETCH : xmcrc_pkg::S_EMIT;
                end
            end
            xmcrc_pkg::S_PAD:
            begin
                if (!crc_busy && fill_full)
                begin
                    state_next = xmcrc_pkg::S_FETCH;
                end
            end
            xmcrc_pkg::S_FETCH:
            begin
                state_next = xmcrc_pkg::S_BYTE;
            end
            xmcrc_pkg::S_BYTE:
            begin
                state_next = word_done ? xmcrc_pkg::S_EMIT : xmcrc_pkg::S_FETCH;
            end
            xmcrc_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = lst_reg ? xmcrc_pkg::S_IDLE : xmcrc_pkg::S_FETCH;
                end
            end
            default:
            begin
                state_next = xmcrc_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        blk_next    = blk_reg;
        final_next  = final_reg;
        pos_next    = pos_reg;
        wd_next     = wd_reg;
        wcnt_next   = wcnt_reg;
        st_next     = st_reg;
        lst_next    = lst_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ram_we      = 1'b0;
        ram_waddr   = fill_reg[xmcrc_pkg::ADDR_W-1:0];
        ram_wdata   = v;
        crc_start   = 1'b0;
        crc_clear   = 1'b0;
        crc_din     = v;

        case (state_reg)
            xmcrc_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    // status-only reject unless overridden below
                    wd_next   = '0;
                    wcnt_next = 4'd0;
                    st_next   = xmcrc_pkg::ST_REJECT;
                    lst_next  = 1'b1;
                    pos_next  = 8'd0;
                    case (phase_reg)
                        xmcrc_pkg::PH_COLLECT:
                        begin
                            if (op == xmcrc_pkg::OP_DATA)
                            begin
                                ram_we    = 1'b1;
                                crc_start = 1'b1;
                                fill_next = fill_reg + 8'd1;
                            end
                            else if (op == xmcrc_pkg::OP_END)
                            begin
                                if (fill_reg == 8'd0)
                                begin
                                    phase_next = xmcrc_pkg::PH_WAIT_EOT;
                                    wd_next    = {56'd0, xmcrc_pkg::CH_EOT};
                                    wcnt_next  = 4'd1;
                                    st_next    = xmcrc_pkg::ST_BUSY;
                                end
                                else
                                begin
                                    final_next = 1'b1;
                                end
                            end
                        end
                        xmcrc_pkg::PH_WAIT_PKT:
                        begin
                            if (op == xmcrc_pkg::OP_REPLY)
                            begin
                                if (is_ack)
                                begin
                                    blk_next  = blk_reg + 8'd1;
                                    fill_next = 8'd0;
                                    crc_clear = 1'b1;
                                    st_next   = xmcrc_pkg::ST_ACKED;
                                    if (final_reg)
                                    begin
                                        final_next = 1'b0;
                                        phase_next = xmcrc_pkg::PH_WAIT_EOT;
                                        wd_next    = {56'd0, xmcrc_pkg::CH_EOT};
                                        wcnt_next  = 4'd1;
                                    end
                                    else
                                    begin
                                        phase_next = xmcrc_pkg::PH_COLLECT;
                                    end
                                end
                                else if (is_can)
                                begin
                                    phase_next = xmcrc_pkg::PH_CANCEL;
                                    st_next    = xmcrc_pkg::ST_CANCEL;
                                end
                                else
                                begin
                                    st_next  = xmcrc_pkg::ST_BUSY;
                                    lst_next = 1'b0;
                                end
                            end
                        end
                        xmcrc_pkg::PH_WAIT_EOT:
                        begin
                            if (op == xmcrc_pkg::OP_REPLY)
                            begin
                                if (is_ack)
                                begin
                                    phase_next = xmcrc_pkg::PH_DONE;
                                    st_next    = xmcrc_pkg::ST_DONE;
                                end
                                else if (is_can)
                                begin
                                    phase_next = xmcrc_pkg::PH_CANCEL;
                                    st_next    = xmcrc_pkg::ST_CANCEL;
                                end
                                else
                                begin
                                    wd_next   = {56'd0, xmcrc_pkg::CH_EOT};
                                    wcnt_next = 4'd1;
                                    st_next   = xmcrc_pkg::ST_BUSY;
                                end
                            end
                        end
                        default:
                        begin
                            st_next = xmcrc_pkg::ST_REJECT;
                        end
                    endcase
                end
            end
            xmcrc_pkg::S_CRC:
            begin
                if (!crc_busy)
                begin
                    st_next = xmcrc_pkg::ST_BUSY;
                    if (fill_full)
                    begin
                        phase_next = xmcrc_pkg::PH_WAIT_PKT;
                        pos_next   = 8'd0;
                        lst_next   = 1'b0;
                    end
                    else
                    begin
                        lst_next = 1'b1;
                    end
                end
            end
            xmcrc_pkg::S_PAD:
            begin
                if (!crc_busy)
                begin
                    if (fill_full)
                    begin
                        phase_next = xmcrc_pkg::PH_WAIT_PKT;
                        pos_next   = 8'd0;
                        st_next    = xmcrc_pkg::ST_BUSY;
                        lst_next   = 1'b0;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = xmcrc_pkg::CH_PAD;
                        crc_start = 1'b1;
                        crc_din   = xmcrc_pkg::CH_PAD;
                        fill_next = fill_reg + 8'd1;
                    end
                end
            end
            xmcrc_pkg::S_BYTE:
            begin
                wd_next[lane_base +: 8] = pkt_byte;
                wcnt_next = wcnt_reg + 4'd1;
                pos_next  = pos_reg + 8'd1;
                lst_next  = (pos_reg == xmcrc_pkg::POS_LAST);
            end
            xmcrc_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {1'b0, st_reg, wcnt_reg, wd_reg};
                    olast_next  = lst_reg;
                    wd_next     = '0;
                    wcnt_next   = 4'd0;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= xmcrc_pkg::S_IDLE;
            phase_reg  <= xmcrc_pkg::PH_COLLECT;
            fill_reg   <= 8'd0;
            blk_reg    <= 8'd1;
            final_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            blk_reg    <= blk_next;
            final_reg  <= final_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        wd_reg    <= wd_next;
        wcnt_reg  <= wcnt_next;
        st_reg    <= st_next;
        lst_reg   <= lst_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign s_axis_tready = (state_reg == xmcrc_pkg::S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

endmodule
